### rtl/core/i2c_master_bit_sequencer_assert.svh
// ---------------------------------------------------------------------------
// I2C master bit sequencer assertion macros
// Assertion helpers used by the sequencer core; empty under synthesis.
// ---------------------------------------------------------------------------
`ifndef I2C_MASTER_BIT_SEQUENCER_ASSERT_SVH
`define I2C_MASTER_BIT_SEQUENCER_ASSERT_SVH
`ifndef SYNTHESIS
`define I2CM_ASSERT_NOW(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
`define I2CM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define I2CM_ASSERT_NOW(lbl, clk, rst_n, expr, msg)
`define I2CM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

### rtl/core/i2cm_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// I2C master bit sequencer package
// Types, codes and constants shared by the sequencer modules.
// ---------------------------------------------------------------------------
package i2cm_pkg;

    localparam int unsigned DELAY_BITS = 16;
    localparam int unsigned CFG_BITS   = 16;

    localparam logic [3:0] RESET_CLOCKS = 4'd9;
    localparam logic [3:0] BYTE_BITS    = 4'd8;

    localparam logic [CFG_BITS-1:0] PHASE_DELAY_RST  = 16'd125;
    localparam logic [CFG_BITS-1:0] RESET_SETTLE_RST = 16'd2500;

    localparam logic [2:0] OP_START     = 3'd0;
    localparam logic [2:0] OP_RESTART   = 3'd1;
    localparam logic [2:0] OP_STOP      = 3'd2;
    localparam logic [2:0] OP_WRITE     = 3'd3;
    localparam logic [2:0] OP_READ      = 3'd4;
    localparam logic [2:0] OP_BUS_RESET = 3'd5;

    localparam logic REG_PHASE_DELAY  = 1'b0;
    localparam logic REG_RESET_SETTLE = 1'b1;

    typedef enum logic [16:0] {
        S_IDLE   = 17'b0_0000_0000_0000_0001,
        S_ST_A   = 17'b0_0000_0000_0000_0010,
        S_ST_B   = 17'b0_0000_0000_0000_0100,
        S_RS_A   = 17'b0_0000_0000_0000_1000,
        S_RS_S   = 17'b0_0000_0000_0001_0000,
        S_RS_B   = 17'b0_0000_0000_0010_0000,
        S_SP_A   = 17'b0_0000_0000_0100_0000,
        S_SP_S   = 17'b0_0000_0000_1000_0000,
        S_SP_B   = 17'b0_0000_0001_0000_0000,
        S_SP_C   = 17'b0_0000_0010_0000_0000,
        S_GAP    = 17'b0_0000_0100_0000_0000,
        S_WB_A   = 17'b0_0000_1000_0000_0000,
        S_WB_B   = 17'b0_0001_0000_0000_0000,
        S_RB_A   = 17'b0_0010_0000_0000_0000,
        S_RB_S   = 17'b0_0100_0000_0000_0000,
        S_RB_B   = 17'b0_1000_0000_0000_0000,
        S_SETTLE = 17'b1_0000_0000_0000_0000
    } t_seq_state;

    typedef struct packed {
        logic [CFG_BITS-1:0] phase_delay_ticks;
        logic [CFG_BITS-1:0] reset_settle_ticks;
    } t_cfg;

    typedef struct packed {
        logic [3:0] pad;
        logic       sda_in;
        logic       scl_in;
        logic       nack;
        logic [7:0] wr_data;
        logic       cmd_valid;
    } t_cmd;

    typedef struct packed {
        logic [1:0] pad;
        logic       arb_lost;
        logic       ack_bit;
        logic [7:0] rd_data;
        logic       done_res;
        logic       ready_res;
        logic       sda_out;
        logic       scl_out;
    } t_res;

endpackage

### rtl/core/i2cm_regs.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// I2C master configuration registers
// APB-style register file holding the phase delay and the reset settle time.
// ---------------------------------------------------------------------------
module i2cm_regs (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [2:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready,
    output i2cm_pkg::t_cfg o_cfg
);
    import i2cm_pkg::*;

    logic [CFG_BITS-1:0] r_phase;
    logic [CFG_BITS-1:0] r_settle;
    logic                wr_en;
    logic                reg_sel;

    assign pready  = 1'b1;
    assign reg_sel = paddr[2];
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PHASE_DELAY_RST;
            r_settle <= RESET_SETTLE_RST;
        end else if (wr_en) begin
            case (reg_sel)
                REG_PHASE_DELAY:  r_phase  <= pwdata[CFG_BITS-1:0];
                REG_RESET_SETTLE: r_settle <= pwdata[CFG_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_sel)
            REG_PHASE_DELAY:  prdata = {{(32-CFG_BITS){1'b0}}, r_phase};
            REG_RESET_SETTLE: prdata = {{(32-CFG_BITS){1'b0}}, r_settle};
            default:          prdata = '0;
        endcase
    end

    assign o_cfg.phase_delay_ticks  = r_phase;
    assign o_cfg.reset_settle_ticks = r_settle;

endmodule

### rtl/core/i2cm_seq.sv
`timescale 1ns / 1ps
`include "i2c_master_bit_sequencer_assert.svh"
// ---------------------------------------------------------------------------
// I2C master bit sequencer core
// Advances the bus state machine by one tick per item and registers the result.
// ---------------------------------------------------------------------------
module i2cm_seq (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  i2cm_pkg::t_cfg i_cfg,
    input  logic           i_cmd_valid,
    input  i2cm_pkg::t_cmd i_cmd,
    input  logic [2:0]     i_op,
    output logic           o_cmd_ready,
    output logic           o_res_valid,
    output i2cm_pkg::t_res o_res,
    input  logic           i_res_ready
);
    import i2cm_pkg::*;

    t_seq_state            r_state, n_state;
    logic [DELAY_BITS-1:0] r_delay, n_delay;
    logic [3:0]            r_bit, n_bit;
    logic [7:0]            r_shift, n_shift;
    logic                  r_scl, n_scl;
    logic                  r_sda, n_sda;
    logic [2:0]            r_op, n_op;
    logic                  r_nack, n_nack;
    logic                  r_stretch, n_stretch;
    logic                  r_ack, n_ack;
    logic                  r_res_valid;
    t_res                  r_res, n_res;

    logic                  fire;
    logic                  fin;
    logic                  lost;
    logic                  waiting;
    logic                  held;
    logic [DELAY_BITS-1:0] phase;

    assign fire        = i_cmd_valid && (!r_res_valid || i_res_ready);
    assign o_cmd_ready = !r_res_valid || i_res_ready;
    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

    assign phase   = DELAY_BITS'(i_cfg.phase_delay_ticks);
    assign waiting = (r_delay != '0);
    assign held    = r_stretch && !i_cmd.scl_in;

    always_comb begin
        n_state   = r_state;
        n_delay   = r_delay;
        n_bit     = r_bit;
        n_shift   = r_shift;
        n_scl     = r_scl;
        n_sda     = r_sda;
        n_op      = r_op;
        n_nack    = r_nack;
        n_stretch = r_stretch;
        n_ack     = r_ack;
        fin       = 1'b0;
        lost      = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (i_cmd.cmd_valid && (i_op <= OP_BUS_RESET)) begin
                    n_op      = i_op;
                    n_nack    = i_cmd.nack;
                    n_bit     = '0;
                    n_stretch = (i_op != OP_BUS_RESET);
                    case (i_op)
                        OP_START: begin
                            if (i_cmd.sda_in) begin
                                n_sda   = 1'b0;
                                n_delay = phase;
                                n_state = S_ST_A;
                            end else begin
                                fin  = 1'b1;
                                lost = 1'b1;
                            end
                        end
                        OP_RESTART: begin
                            n_sda   = 1'b1;
                            n_delay = phase;
                            n_state = S_RS_A;
                        end
                        OP_STOP: begin
                            n_sda   = 1'b0;
                            n_delay = phase;
                            n_state = S_SP_A;
                        end
                        OP_WRITE: begin
                            n_shift = i_cmd.wr_data;
                            n_sda   = i_cmd.wr_data[7];
                            n_delay = phase;
                            n_state = S_WB_A;
                        end
                        OP_READ: begin
                            n_shift = '0;
                            n_sda   = 1'b1;
                            n_delay = phase;
                            n_state = S_RB_A;
                        end
                        default: begin
                            if (i_cmd.sda_in) begin
                                n_sda   = 1'b0;
                                n_delay = phase;
                                n_state = S_ST_A;
                            end else begin
                                n_sda   = 1'b1;
                                n_delay = phase;
                                n_state = S_WB_A;
                            end
                        end
                    endcase
                end
            end
            S_ST_A: begin
                if (waiting) begin
                    n_delay = r_delay - 1'b1;
                end else begin
                    n_scl   = 1'b0;
                    n_delay = phase;
                    n_state = S_ST_B;
                end
            end
            S_ST_B: begin
                if (waiting) begin
                    n_delay = r_delay - 1'b1;
                end else if (r_op == OP_BUS_RESET) begin
                    n_delay = phase;
                    if (r_bit == '0) begin
                        n_sda   = 1'b1;
                        n_state = S_WB_A;
                    end else begin
                        n_sda   = 1'b0;
                        n_state = S_SP_A;
                    end
                end else begin
                    fin = 1'b1;
                end
            end
            S_RS_A: begin
                if (waiting) begin
                    n_delay = r_delay - 1'b1;
                end else begin
                    n_scl   = 1'b1;
                    n_state = S_RS_S;
                end
            end
            S_RS_S: begin
                if (!held) begin
                    n_delay = phase;
                    n_state = S_RS_B;
                end
            end
            S_RS_B: begin
                if (waiting) begin
                    n_delay = r_delay - 1'b1;
                end else if (!i_cmd.sda_in) begin
                    if (r_op == OP_BUS_RESET) begin
                        n_sda   = 1'b0;
                        n_delay = phase;
                        n_state = S_SP_A;
                    end else begin
                        fin  = 1'b1;
                        lost = 1'b1;
                    end
                end else begin
                    n_sda   = 1'b0;
                    n_delay = phase;
                    n_state = S_ST_A;
                end
            end
            S_SP_A: begin
                if (waiting) begin
                    n_delay = r_delay - 1'b1;
                end else begin
                    n_scl   = 1'b1;
                    n_state = S_SP_S;
                end
            end
            S_SP_S: begin
                if (!held) begin
                    n_delay = phase;
                    n_state = S_SP_B;
                end
            end
            S_SP_B: begin
                if (waiting) begin
                    n_delay = r_delay - 1'b1;
                end else begin
                    n_sda   = 1'b1;
                    n_delay = phase;
                    n_state = S_SP_C;
                end
            end
            S_SP_C: begin
                if (waiting) begin
                    n_delay = r_delay - 1'b1;
                end else if (r_op == OP_BUS_RESET) begin
                    n_delay = DELAY_BITS'(i_cfg.reset_settle_ticks);
                    n_state = S_SETTLE;
                end else begin
                    fin  = 1'b1;
                    lost = !i_cmd.sda_in;
                end
            end
            S_GAP: begin
                case (r_op)
                    OP_WRITE: begin
                        n_delay = phase;
                        if (r_bit < BYTE_BITS) begin
                            n_sda   = r_shift[7];
                            n_state = S_WB_A;
                        end else if (r_bit == BYTE_BITS) begin
                            n_sda   = 1'b1;
                            n_state = S_RB_A;
                        end else begin
                            fin = 1'b1;
                        end
                    end
                    OP_READ: begin
                        n_delay = phase;
                        if (r_bit < BYTE_BITS) begin
                            n_sda   = 1'b1;
                            n_state = S_RB_A;
                        end else if (r_bit == BYTE_BITS) begin
                            n_sda   = r_nack;
                            n_state = S_WB_A;
                        end else begin
                            fin = 1'b1;
                        end
                    end
                    OP_BUS_RESET: begin
                        n_sda   = 1'b1;
                        n_delay = phase;
                        if (r_bit < RESET_CLOCKS) begin
                            n_state = S_WB_A;
                        end else begin
                            n_state = S_RS_A;
                        end
                    end
                    default: begin
                        fin = 1'b1;
                    end
                endcase
            end
            S_WB_A: begin
                if (waiting) begin
                    n_delay = r_delay - 1'b1;
                end else begin
                    n_scl   = 1'b1;
                    n_delay = phase;
                    n_state = S_WB_B;
                end
            end
            S_WB_B: begin
                if (waiting) begin
                    n_delay = r_delay - 1'b1;
                end else if (held) begin
                    n_state = S_WB_B;
                end else if (r_sda && !i_cmd.sda_in && (r_op != OP_BUS_RESET)) begin
                    fin  = 1'b1;
                    lost = 1'b1;
                end else begin
                    n_scl = 1'b0;
                    if (r_op == OP_WRITE) begin
                        n_shift = {r_shift[6:0], 1'b0};
                    end
                    n_bit   = r_bit + 1'b1;
                    n_state = S_GAP;
                end
            end
            S_RB_A: begin
                if (waiting) begin
                    n_delay = r_delay - 1'b1;
                end else begin
                    n_scl   = 1'b1;
                    n_state = S_RB_S;
                end
            end
            S_RB_S: begin
                if (!held) begin
                    n_delay = phase;
                    n_state = S_RB_B;
                end
            end
            S_RB_B: begin
                if (waiting) begin
                    n_delay = r_delay - 1'b1;
                end else begin
                    n_scl = 1'b0;
                    if (r_op == OP_READ) begin
                        n_shift = {r_shift[6:0], i_cmd.sda_in};
                    end else if (r_op == OP_WRITE) begin
                        n_ack = i_cmd.sda_in;
                    end
                    n_bit   = r_bit + 1'b1;
                    n_state = S_GAP;
                end
            end
            S_SETTLE: begin
                if (waiting) begin
                    n_delay = r_delay - 1'b1;
                end else begin
                    fin = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (fin) begin
            n_state = S_IDLE;
        end

        n_res           = '0;
        n_res.scl_out   = n_scl;
        n_res.sda_out   = n_sda;
        n_res.ready_res = (r_state == S_IDLE);
        n_res.done_res  = fin;
        n_res.rd_data   = (fin && (n_op == OP_READ)) ? n_shift : 8'h00;
        n_res.ack_bit   = n_ack;
        n_res.arb_lost  = fin && lost;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_delay     <= '0;
            r_bit       <= '0;
            r_shift     <= '0;
            r_scl       <= 1'b1;
            r_sda       <= 1'b1;
            r_op        <= OP_START;
            r_nack      <= 1'b0;
            r_stretch   <= 1'b0;
            r_ack       <= 1'b0;
            r_res_valid <= 1'b0;
        end else begin
            if (fire) begin
                r_state   <= n_state;
                r_delay   <= n_delay;
                r_bit     <= n_bit;
                r_shift   <= n_shift;
                r_scl     <= n_scl;
                r_sda     <= n_sda;
                r_op      <= n_op;
                r_nack    <= n_nack;
                r_stretch <= n_stretch;
                r_ack     <= n_ack;
            end
            if (fire) begin
                r_res_valid <= 1'b1;
            end else if (i_res_ready) begin
                r_res_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_res <= n_res;
        end
    end

    `I2CM_ASSERT_NOW(a_state_onehot, i_clk, i_rst_n, $onehot(r_state), "state not one-hot")
    `I2CM_ASSERT_NOW(a_bit_bound, i_clk, i_rst_n, r_bit <= RESET_CLOCKS, "bit count overrun")
    `I2CM_ASSERT_NEXT(a_done_idle, i_clk, i_rst_n, fire && fin, r_state == S_IDLE, "done not idle")
    `I2CM_ASSERT_NEXT(a_gap_once, i_clk, i_rst_n, fire && (r_state == S_GAP), r_state != S_GAP, "gap repeated")

endmodule

### rtl/core/i2c_master_bit_sequencer.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// I2C master bit sequencer
// Top level: input register, configuration registers and the bus sequencer.
// ---------------------------------------------------------------------------
// Each item on the slave stream is one bus tick: the sampled SCL and SDA
// levels plus an optional command (start, restart, stop, write byte, read
// byte, bus reset) that is taken only while the sequencer is idle.
// Every item yields exactly one item on the master stream with the SCL and
// SDA drives, the idle flag, the done pulse, the read byte, the ACK bit of
// the last write and the arbitration-lost flag.
// An item is captured in the input register, then passes the sequencer logic
// into the result register, from which its result is offered to the receiver.
// One item is accepted per cycle when the output is not stalled.
// When the receiver holds tready low, the result register keeps its item and
// the input register stalls behind it; nothing is lost or repeated.
// Synchronous reset releases both lines, returns to idle and loads the
// delay registers with 125 and 2500 ticks. The user writes the delay registers
// over the APB port only while no command runs; the block does not enforce it.
// ---------------------------------------------------------------------------
module i2c_master_bit_sequencer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // cmd_valid[0], wr_data[8:1], nack[9], scl_in[10], sda_in[11], zero[15:12]
    input  logic [15:0] s_axis_tdata,
    // op[2:0]
    input  logic [2:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // scl_out[0], sda_out[1], ready_res[2], done_res[3], rd_data[11:4],
    // ack_bit[12], arb_lost[13], zero[15:14]
    output logic [15:0] m_axis_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import i2cm_pkg::*;

    logic       r_in_valid;
    t_cmd       r_in_cmd;
    logic [2:0] r_in_op;
    logic       seq_ready;
    t_cfg       cfg;
    t_res       res;

    assign s_axis_tready = !r_in_valid || seq_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_cmd <= t_cmd'(s_axis_tdata);
            r_in_op  <= s_axis_tuser;
        end
    end

    i2cm_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    i2cm_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_cmd_valid (r_in_valid),
        .i_cmd       (r_in_cmd),
        .i_op        (r_in_op),
        .o_cmd_ready (seq_ready),
        .o_res_valid (m_axis_tvalid),
        .o_res       (res),
        .i_res_ready (m_axis_tready)
    );

    assign m_axis_tdata = 16'(res);

endmodule
